### rtl/core/rfs_pkg.sv
// ============================================================================
// rfs_pkg
// Shared codes, widths and constants of the replan fallback sequencer.
// ============================================================================
package rfs_pkg;

    // Event kinds
    localparam logic [1:0] FUNC_COLLISION = 2'd0;
    localparam logic [1:0] FUNC_REJECTED  = 2'd1;
    localparam logic [1:0] FUNC_RESET     = 2'd2;

    // Actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_ESTOP   = 3'd1;
    localparam logic [2:0] ACT_RETRY   = 3'd2;
    localparam logic [2:0] ACT_SHORTEN = 3'd3;
    localparam logic [2:0] ACT_WAIT    = 3'd4;

    // Modes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_ESTOP    = 3'd1;
    localparam logic [2:0] MODE_RETRYING = 3'd2;
    localparam logic [2:0] MODE_SHORTEN  = 3'd3;
    localparam logic [2:0] MODE_WAITING  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAX_RETRIES = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_STEP = 3'd1;
    localparam logic [2:0] CFG_RATIO_COUNT = 3'd2;
    localparam logic [2:0] CFG_RATIO_A     = 3'd3;
    localparam logic [2:0] CFG_RATIO_B     = 3'd4;
    localparam logic [2:0] CFG_RATIO_C     = 3'd5;
    localparam logic [2:0] CFG_RATIO_D     = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Field widths
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 16;
    localparam int RATIO_W  = 16;
    localparam int COUNT_W  = 3;
    localparam int RETRY_W  = 8;
    localparam int NUM_TAB  = 4;

    // Ratios usable at most; a larger ratio_count is clamped to this
    localparam logic [COUNT_W-1:0] MAX_RATIOS = 3'd4;

    // 1.0 in Q16.16
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 32'h0001_0000;

    // Reset values of the configuration registers
    localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 8'd3;
    localparam logic [STEP_W-1:0]  RST_WEIGHT_STEP = 16'd512;
    localparam logic [COUNT_W-1:0] RST_RATIO_COUNT = 3'd2;
    localparam logic [RATIO_W-1:0] RST_RATIO_A     = 16'd49152;
    localparam logic [RATIO_W-1:0] RST_RATIO_B     = 16'd32768;
    localparam logic [RATIO_W-1:0] RST_RATIO_C     = 16'd16384;
    localparam logic [RATIO_W-1:0] RST_RATIO_D     = 16'd8192;

endpackage

### rtl/core/rfs_evt_if.sv
// ============================================================================
// rfs_evt_if
// Event channel: valid/ready handshake carrying one planner event.
// ============================================================================
interface rfs_evt_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic                          imminent;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] target_x;
    logic signed [COORD_WIDTH-1:0] target_y;
    logic signed [COORD_WIDTH-1:0] target_z;

    modport source (
        output valid, func, imminent, pos_x, pos_y, pos_z, target_x, target_y, target_z,
        input  ready
    );
    modport sink (
        input  valid, func, imminent, pos_x, pos_y, pos_z, target_x, target_y, target_z,
        output ready
    );
endinterface

### rtl/core/rfs_res_if.sv
// ============================================================================
// rfs_res_if
// Result channel: valid/ready handshake carrying one fallback decision.
// ============================================================================
interface rfs_res_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    action;
    logic [2:0]                    mode;
    logic [31:0]                   collision_weight;
    logic                          goal_valid;
    logic signed [COORD_WIDTH-1:0] new_goal_x;
    logic signed [COORD_WIDTH-1:0] new_goal_y;
    logic signed [COORD_WIDTH-1:0] new_goal_z;

    modport source (
        output valid, action, mode, collision_weight, goal_valid,
               new_goal_x, new_goal_y, new_goal_z,
        input  ready
    );
    modport sink (
        input  valid, action, mode, collision_weight, goal_valid,
               new_goal_x, new_goal_y, new_goal_z,
        output ready
    );
endinterface

### rtl/core/rfs_cfg_if.sv
// ============================================================================
// rfs_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface rfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rfs_pkg::CFG_INDEX_W-1:0] index;
    logic [rfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

### rtl/core/replan_fallback_sequencer.sv
// ============================================================================
// replan_fallback_sequencer
// Fallback cascade for a trajectory planner: emergency stop, weighted
// retries, shortened goals, then wait.
// ============================================================================
// The block answers every event with one result. An event is taken into an
// input register, where the position-to-target differences are formed. With
// the event in the input register, the block decides the action from the
// sequencer state. It runs the weight multiply and the three goal
// interpolation multiplies, updates the state and loads the result register
// once that register is empty or being taken, which raises result valid. A
// new event can be taken every cycle as long as results are taken. The
// result register and the input register each hold one item, so a stalled
// result side backs up to the event side after two items. Configuration
// writes are always accepted and must only be issued while no event is in
// flight.
module replan_fallback_sequencer #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rfs_evt_if.sink    evt,
    rfs_res_if.source  res,
    rfs_cfg_if.sink    cfg
);

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MUL_W  = DIFF_W + rfs_pkg::RATIO_W + 1;
    localparam int WPROD_W = rfs_pkg::WEIGHT_W + rfs_pkg::STEP_W;

    // Configuration registers
    logic [rfs_pkg::RETRY_W-1:0] max_retries_reg;
    logic [rfs_pkg::STEP_W-1:0]  weight_step_reg;
    logic [rfs_pkg::COUNT_W-1:0] ratio_count_reg;
    logic [rfs_pkg::RATIO_W-1:0] ratio_tab_reg [rfs_pkg::NUM_TAB];

    // Sequencer state
    logic [2:0]                   mode_reg;
    logic [2:0]                   mode_next;
    logic [rfs_pkg::RETRY_W-1:0]  retries_reg;
    logic [rfs_pkg::RETRY_W-1:0]  retries_next;
    logic [rfs_pkg::COUNT_W-1:0]  ratio_index_reg;
    logic [rfs_pkg::COUNT_W-1:0]  ratio_index_next;
    logic [rfs_pkg::WEIGHT_W-1:0] weight_reg;
    logic [rfs_pkg::WEIGHT_W-1:0] weight_next;

    // Input stage
    logic                          in_valid_reg;
    logic [1:0]                    func_reg;
    logic                          imm_reg;
    logic signed [COORD_WIDTH-1:0] pos_reg  [3];
    logic signed [DIFF_W-1:0]      diff_reg [3];
    logic signed [COORD_WIDTH-1:0] tgt_in   [3];
    logic signed [COORD_WIDTH-1:0] pos_in   [3];

    // Result stage
    logic                          out_valid_reg;
    logic [2:0]                    action_reg;
    logic [2:0]                    mode_out_reg;
    logic [rfs_pkg::WEIGHT_W-1:0]  cw_reg;
    logic                          gv_reg;
    logic signed [COORD_WIDTH-1:0] goal_reg [3];

    // Datapath
    logic                          evt_xfer;
    logic                          advance;
    logic                          out_free;
    logic [rfs_pkg::COUNT_W-1:0]   eff_count;
    logic [rfs_pkg::RATIO_W-1:0]   ratio_sel;
    logic [WPROD_W-1:0]            wprod;
    logic [WPROD_W-9:0]            wshift;
    logic [rfs_pkg::WEIGHT_W-1:0]  wsat;
    logic signed [MUL_W-1:0]       mul      [3];
    logic signed [MUL_W-1:0]       rsum     [3];
    logic signed [COORD_WIDTH-1:0] goal_val [3];
    logic [2:0]                    action_c;
    logic [rfs_pkg::WEIGHT_W-1:0]  cw_c;
    logic                          gv_c;

    // Handshake
    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign evt.ready = !in_valid_reg || advance;
    assign evt_xfer  = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    assign pos_in[0] = evt.pos_x;
    assign pos_in[1] = evt.pos_y;
    assign pos_in[2] = evt.pos_z;
    assign tgt_in[0] = evt.target_x;
    assign tgt_in[1] = evt.target_y;
    assign tgt_in[2] = evt.target_z;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg   <= rfs_pkg::RST_MAX_RETRIES;
            weight_step_reg   <= rfs_pkg::RST_WEIGHT_STEP;
            ratio_count_reg   <= rfs_pkg::RST_RATIO_COUNT;
            ratio_tab_reg[0]  <= rfs_pkg::RST_RATIO_A;
            ratio_tab_reg[1]  <= rfs_pkg::RST_RATIO_B;
            ratio_tab_reg[2]  <= rfs_pkg::RST_RATIO_C;
            ratio_tab_reg[3]  <= rfs_pkg::RST_RATIO_D;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rfs_pkg::CFG_MAX_RETRIES: max_retries_reg  <= cfg.data[rfs_pkg::RETRY_W-1:0];
                rfs_pkg::CFG_WEIGHT_STEP: weight_step_reg  <= cfg.data;
                rfs_pkg::CFG_RATIO_COUNT: ratio_count_reg  <= cfg.data[rfs_pkg::COUNT_W-1:0];
                rfs_pkg::CFG_RATIO_A:     ratio_tab_reg[0] <= cfg.data;
                rfs_pkg::CFG_RATIO_B:     ratio_tab_reg[1] <= cfg.data;
                rfs_pkg::CFG_RATIO_C:     ratio_tab_reg[2] <= cfg.data;
                rfs_pkg::CFG_RATIO_D:     ratio_tab_reg[3] <= cfg.data;
                default: ;
            endcase
        end
    end

    // Capture event and form differences
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt.ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_xfer)
        begin
            func_reg <= evt.func;
            imm_reg  <= evt.imminent;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= pos_in[i];
                diff_reg[i] <= DIFF_W'(tgt_in[i]) - DIFF_W'(pos_in[i]);
            end
        end
    end

    // Clamp ratio count and pick the current ratio
    assign eff_count = (ratio_count_reg > rfs_pkg::MAX_RATIOS) ? rfs_pkg::MAX_RATIOS
                                                               : ratio_count_reg;
    assign ratio_sel = ratio_tab_reg[ratio_index_reg[1:0]];

    // Scale weight by Q8.8 step, saturate
    assign wprod  = WPROD_W'(weight_reg) * WPROD_W'(weight_step_reg);
    assign wshift = wprod[WPROD_W-1:8];
    assign wsat   = (|wshift[WPROD_W-9:rfs_pkg::WEIGHT_W]) ? '1
                                                           : wshift[rfs_pkg::WEIGHT_W-1:0];

    // Interpolate goal, round half up
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul[i]      = MUL_W'(diff_reg[i]) * MUL_W'($signed({1'b0, ratio_sel}));
            rsum[i]     = mul[i] + MUL_W'(32768);
            goal_val[i] = pos_reg[i] + rsum[i][COORD_WIDTH+15:16];
        end
    end

    // Decide action and next state
    always_comb
    begin
        mode_next        = mode_reg;
        retries_next     = retries_reg;
        ratio_index_next = ratio_index_reg;
        weight_next      = weight_reg;
        action_c         = rfs_pkg::ACT_NONE;
        cw_c             = rfs_pkg::ONE_Q16;
        gv_c             = 1'b0;
        case (func_reg)
            rfs_pkg::FUNC_COLLISION:
            begin
                if (imm_reg)
                begin
                    mode_next = rfs_pkg::MODE_ESTOP;
                    action_c  = rfs_pkg::ACT_ESTOP;
                end
                else if (retries_reg < max_retries_reg)
                begin
                    weight_next  = wsat;
                    retries_next = retries_reg + 1'b1;
                    mode_next    = rfs_pkg::MODE_RETRYING;
                    action_c     = rfs_pkg::ACT_RETRY;
                    cw_c         = wsat;
                end
                else if (ratio_index_reg < eff_count)
                begin
                    mode_next = rfs_pkg::MODE_SHORTEN;
                    action_c  = rfs_pkg::ACT_SHORTEN;
                    gv_c      = 1'b1;
                end
                else
                begin
                    mode_next = rfs_pkg::MODE_WAITING;
                    action_c  = rfs_pkg::ACT_WAIT;
                end
            end
            rfs_pkg::FUNC_REJECTED:
            begin
                if (ratio_index_reg < eff_count)
                begin
                    ratio_index_next = ratio_index_reg + 1'b1;
                end
            end
            rfs_pkg::FUNC_RESET:
            begin
                mode_next        = rfs_pkg::MODE_NORMAL;
                retries_next     = '0;
                ratio_index_next = '0;
                weight_next      = rfs_pkg::ONE_Q16;
            end
            default: ;
        endcase
    end

    // Advance sequencer state on each processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= rfs_pkg::MODE_NORMAL;
            retries_reg     <= '0;
            ratio_index_reg <= '0;
            weight_reg      <= rfs_pkg::ONE_Q16;
        end
        else if (advance)
        begin
            mode_reg        <= mode_next;
            retries_reg     <= retries_next;
            ratio_index_reg <= ratio_index_next;
            weight_reg      <= weight_next;
        end
    end

    // Hold result until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg   <= action_c;
            mode_out_reg <= mode_next;
            cw_reg       <= cw_c;
            gv_reg       <= gv_c;
            for (int i = 0; i < 3; i++)
            begin
                goal_reg[i] <= gv_c ? goal_val[i] : '0;
            end
        end
    end

    assign res.valid            = out_valid_reg;
    assign res.action           = action_reg;
    assign res.mode             = mode_out_reg;
    assign res.collision_weight = cw_reg;
    assign res.goal_valid       = gv_reg;
    assign res.new_goal_x       = goal_reg[0];
    assign res.new_goal_y       = goal_reg[1];
    assign res.new_goal_z       = goal_reg[2];

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Self-checking bench for replan_fallback_sequencer. Planner events go in on
// the event channel with bursty pacing, and decisions come out under a random
// stall pattern with one long hold-off. A cycle-free predictor of the
// stop / retry / shorten / wait cascade forms the expected decision for every
// event transfer; each result transfer is checked field by field, in order.
// Configuration is rewritten between drained phases, corner values included.
// ============================================================================
module testbench;

    localparam logic [1:0] FUNC_UNUSED   = 2'd3;
    localparam logic [2:0] CFG_UNUSED    = 3'd7;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         MAX_REPORTS   = 10;
    localparam int         HOLD_CYCLES   = 200;
    localparam logic [31:0] COORD_MIN    = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic        imminent;
        logic [31:0] px, py, pz;
        logic [31:0] tx, ty, tz;
    } planner_event_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  mode;
        logic [31:0] weight;
        logic        goal_valid;
        logic [31:0] gx, gy, gz;
    } decision_t;

    logic clk;
    logic rst_n;

    rfs_evt_if #(.COORD_WIDTH(32)) evt ();
    rfs_res_if #(.COORD_WIDTH(32)) res ();
    rfs_cfg_if                     cfg ();

    replan_fallback_sequencer #(.COORD_WIDTH(32)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    // Predictor copy of the configuration registers
    logic [7:0]  cfg_retries;
    logic [15:0] cfg_step;
    logic [2:0]  cfg_count;
    logic [15:0] cfg_ratio [4];

    // Predictor copy of the sequencer state
    logic [2:0]  st_mode;
    logic [7:0]  st_retries;
    logic [2:0]  st_ratio_idx;
    logic [31:0] st_weight;

    decision_t   pending_decisions [$];

    int fault_count    = 0;
    int events_sent    = 0;
    int results_seen   = 0;
    int cfg_writes     = 0;
    int settings_used  = 0;
    int action_seen [8] = '{default: 0};

    // Pacing controls
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int burst_left = 0;
    int rx_run     = 0;
    bit rx_open    = 1'b1;
    int hold_req   = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("FAIL replan_fallback_sequencer");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void clear_sequencer();
        st_mode      = rfs_pkg::MODE_NORMAL;
        st_retries   = '0;
        st_ratio_idx = '0;
        st_weight    = rfs_pkg::ONE_Q16;
    endfunction

    // Interpolate pos toward target by a Q0.16 ratio, rounding half up
    function automatic logic [31:0] shorten_coord(input logic [31:0] p,
                                                  input logic [31:0] t,
                                                  input logic [15:0] ratio);
        longint span;
        longint offset;
        span   = longint'(signed'(t)) - longint'(signed'(p));
        offset = (span * longint'(ratio) + 64'sd32768) >>> 16;
        return p + offset[31:0];
    endfunction

    function automatic decision_t plan_fallback(input planner_event_t ev);
        decision_t   d;
        logic [63:0] grown;
        logic [2:0]  usable;
        logic [15:0] ratio;
        d          = '0;
        d.action   = rfs_pkg::ACT_NONE;
        d.weight   = rfs_pkg::ONE_Q16;
        usable     = (cfg_count > rfs_pkg::MAX_RATIOS) ? rfs_pkg::MAX_RATIOS : cfg_count;
        case (ev.func)
            rfs_pkg::FUNC_COLLISION:
            begin
                if (ev.imminent)
                begin
                    st_mode  = rfs_pkg::MODE_ESTOP;
                    d.action = rfs_pkg::ACT_ESTOP;
                end
                else if (st_retries < cfg_retries)
                begin
                    grown      = ({32'd0, st_weight} * {48'd0, cfg_step}) >> 8;
                    st_weight  = (grown > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : grown[31:0];
                    st_retries = st_retries + 8'd1;
                    st_mode    = rfs_pkg::MODE_RETRYING;
                    d.action   = rfs_pkg::ACT_RETRY;
                    d.weight   = st_weight;
                end
                else if (st_ratio_idx < usable)
                begin
                    ratio        = cfg_ratio[st_ratio_idx[1:0]];
                    d.gx         = shorten_coord(ev.px, ev.tx, ratio);
                    d.gy         = shorten_coord(ev.py, ev.ty, ratio);
                    d.gz         = shorten_coord(ev.pz, ev.tz, ratio);
                    d.goal_valid = 1'b1;
                    st_mode      = rfs_pkg::MODE_SHORTEN;
                    d.action     = rfs_pkg::ACT_SHORTEN;
                end
                else
                begin
                    st_mode  = rfs_pkg::MODE_WAITING;
                    d.action = rfs_pkg::ACT_WAIT;
                end
            end
            rfs_pkg::FUNC_REJECTED:
            begin
                if (st_ratio_idx < usable)
                    st_ratio_idx = st_ratio_idx + 3'd1;
            end
            rfs_pkg::FUNC_RESET:
                clear_sequencer();
            default:
                ;  // unused event code leaves the state alone
        endcase
        d.mode = st_mode;
        return d;
    endfunction

    function automatic void apply_register(input logic [2:0] index, input logic [15:0] data);
        case (index)
            rfs_pkg::CFG_MAX_RETRIES: cfg_retries  = data[7:0];
            rfs_pkg::CFG_WEIGHT_STEP: cfg_step     = data;
            rfs_pkg::CFG_RATIO_COUNT: cfg_count    = data[2:0];
            rfs_pkg::CFG_RATIO_A:     cfg_ratio[0] = data;
            rfs_pkg::CFG_RATIO_B:     cfg_ratio[1] = data;
            rfs_pkg::CFG_RATIO_C:     cfg_ratio[2] = data;
            rfs_pkg::CFG_RATIO_D:     cfg_ratio[3] = data;
            default:         ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            log_fault($sformatf("result %0d field %s expected %h got %h",
                                results_seen, name, want, got));
    endtask

    always @(posedge clk)
    begin : result_check
        decision_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_decisions.size() == 0)
                log_fault("result transfer with no event outstanding");
            else
            begin
                want = pending_decisions.pop_front();
                check_field("action", 32'(want.action), 32'(res.action));
                check_field("mode", 32'(want.mode), 32'(res.mode));
                check_field("collision_weight", want.weight, res.collision_weight);
                check_field("goal_valid", 32'(want.goal_valid), 32'(res.goal_valid));
                check_field("new_goal_x", want.gx, res.new_goal_x);
                check_field("new_goal_y", want.gy, res.new_goal_y);
                check_field("new_goal_z", want.gz, res.new_goal_z);
            end
            action_seen[res.action] = action_seen[res.action] + 1;
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random ready runs, blocked while a hold-off is counting down
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_open = !stalls_on || ($urandom_range(0, 3) != 0);
            rx_run  = $urandom_range(1, 8);
        end
        rx_run    = rx_run - 1;
        res.ready = rx_open && (hold_left == 0);
    end

    // Count down a requested hold-off in cycles
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req != hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= hold_req;
        end
    end

    // ------------------------------------------------------------------------
    // Sender side; every task is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_event(input planner_event_t ev);
        evt.valid    = 1'b1;
        evt.func     = ev.func;
        evt.imminent = ev.imminent;
        evt.pos_x    = ev.px;
        evt.pos_y    = ev.py;
        evt.pos_z    = ev.pz;
        evt.target_x = ev.tx;
        evt.target_y = ev.ty;
        evt.target_z = ev.tz;
        @(posedge clk);
        while (!evt.ready)
            @(posedge clk);
        pending_decisions.push_back(plan_fallback(ev));
        events_sent++;
        @(negedge clk);
        // Hold valid through a burst; drop it for a random gap between bursts
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                evt.valid = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // Pause the sender until every decision is back, then let the block settle
    task automatic drain();
        evt.valid = 1'b0;
        while (pending_decisions.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [15:0] data);
        cfg.valid = 1'b1;
        cfg.index = index;
        cfg.data  = data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        apply_register(index, data);
        cfg_writes++;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_config(input logic [15:0] retries, input logic [15:0] step,
                              input logic [15:0] count, input logic [15:0] ra,
                              input logic [15:0] rb, input logic [15:0] rc,
                              input logic [15:0] rd);
        drain();
        cfg_write(rfs_pkg::CFG_MAX_RETRIES, retries);
        cfg_write(rfs_pkg::CFG_WEIGHT_STEP, step);
        cfg_write(rfs_pkg::CFG_RATIO_COUNT, count);
        cfg_write(rfs_pkg::CFG_RATIO_A, ra);
        cfg_write(rfs_pkg::CFG_RATIO_B, rb);
        cfg_write(rfs_pkg::CFG_RATIO_C, rc);
        cfg_write(rfs_pkg::CFG_RATIO_D, rd);
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------
    function automatic planner_event_t mk_event(input logic [1:0] func, input logic imm,
                                                input logic [31:0] p, input logic [31:0] t);
        planner_event_t ev;
        ev.func     = func;
        ev.imminent = imm;
        ev.px = p;
        ev.tx = t;
        ev.py = t;
        ev.ty = p;
        ev.pz = p ^ 32'h5555_5555;
        ev.tz = t;
        return ev;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Mostly cascade-driving collision reports, with rejects, resets and noise
    function automatic planner_event_t rand_event();
        planner_event_t ev;
        int pick;
        pick        = $urandom_range(0, 99);
        ev.imminent = 1'($urandom_range(0, 1));
        if (pick < 66)
        begin
            ev.func     = rfs_pkg::FUNC_COLLISION;
            ev.imminent = 1'b0;
        end
        else if (pick < 72)
        begin
            ev.func     = rfs_pkg::FUNC_COLLISION;
            ev.imminent = 1'b1;
        end
        else if (pick < 86)
            ev.func = rfs_pkg::FUNC_REJECTED;
        else if (pick < 95)
            ev.func = rfs_pkg::FUNC_RESET;
        else
            ev.func = FUNC_UNUSED;
        ev.px = rand_coord();
        ev.py = rand_coord();
        ev.pz = rand_coord();
        // Targets near the position half the time, anywhere otherwise
        ev.tx = $urandom_range(0, 1) ? ev.px + $urandom_range(0, 65535) - 32768 : rand_coord();
        ev.ty = $urandom_range(0, 1) ? ev.py + $urandom_range(0, 65535) - 32768 : rand_coord();
        ev.tz = $urandom_range(0, 1) ? ev.pz + $urandom_range(0, 65535) - 32768 : rand_coord();
        return ev;
    endfunction

    function automatic logic [15:0] rand_ratio();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h8000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] rand_step();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd256;
            3: return 16'd257;
            4: return 16'hFFFF;
            5: return rfs_pkg::RST_WEIGHT_STEP;
            default: return 16'($urandom_range(257, 1024));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walk the whole cascade under the reset configuration
    task automatic test_directed();
        send_event(mk_event(FUNC_UNUSED, 1'b1, COORD_MAX, COORD_MIN));
        send_event(mk_event(rfs_pkg::FUNC_REJECTED, 1'b0, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_RESET, 1'b0, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, COORD_MIN, COORD_MAX));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, COORD_MAX, COORD_MIN));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, 32'hFFFF_FFFF, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, COORD_MIN, COORD_MAX));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, COORD_MAX, COORD_MIN));
        send_event(mk_event(rfs_pkg::FUNC_REJECTED, 1'b0, 32'h0, 32'h0));
        // Half-way ratio with a unit step lands exactly on a rounding tie
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, 32'h0, 32'h1));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, 32'hFFFF_FFFF, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_REJECTED, 1'b0, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_REJECTED, 1'b0, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, 32'h1234_5678, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b1, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_REJECTED, 1'b1, 32'h0, 32'h0));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, 32'h0, COORD_MAX));
        send_event(mk_event(rfs_pkg::FUNC_RESET, 1'b1, COORD_MIN, COORD_MIN));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b0, COORD_MAX, COORD_MAX));
        send_event(mk_event(rfs_pkg::FUNC_COLLISION, 1'b1, 32'h0, 32'h0));
        send_event(mk_event(FUNC_UNUSED, 1'b0, 32'h0, 32'hFFFF_FFFF));
    endtask

    // Register corners: zero and unit steps, empty and oversized ratio tables
    task automatic test_config_corners();
        for (int k = 0; k < 5; k++)
        begin
            case (k)
                0: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0);
                1: set_config(16'hFF01, 16'h0001, 16'h0001, 16'h0, 16'h1, 16'h1, 16'h1);
                2: set_config(16'h0002, 16'h0100, 16'hFFFC, 16'hFFFF, 16'h1, 16'h8000,
                              16'hFFFF);
                3: set_config(16'h0003, 16'h0101, 16'h0005, rand_ratio(), rand_ratio(),
                              rand_ratio(), rand_ratio());
                default: set_config(16'h0001, 16'hFFFF, 16'h0007, 16'h8000, 16'h4000,
                                    16'hC000, 16'h0001);
            endcase
            if (k == 3)
                cfg_write(CFG_UNUSED, 16'($urandom()));
            send_event(mk_event(rfs_pkg::FUNC_RESET, 1'b0, 32'h0, 32'h0));
            repeat (14)
                send_event(rand_event());
        end
    endtask

    // Random phases, each under its own configuration and pacing
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                set_config(16'h00FF, 16'hFFFF, 16'h0007, rand_ratio(), rand_ratio(),
                           rand_ratio(), rand_ratio());
            else
                set_config(($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4))
                                                      : 16'($urandom()),
                           rand_step(), 16'($urandom()), rand_ratio(), rand_ratio(),
                           rand_ratio(), rand_ratio());
            gaps_on   = (phase % 3) != 2;
            stalls_on = (phase % 4) != 3;
            repeat (110)
                send_event(rand_event());
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Block the output for a long stretch while events keep coming
    task automatic test_backpressure();
        set_config(16'(rfs_pkg::RST_MAX_RETRIES), rfs_pkg::RST_WEIGHT_STEP, 16'h0004,
                   rfs_pkg::RST_RATIO_A, rfs_pkg::RST_RATIO_B,
                   rfs_pkg::RST_RATIO_C, rfs_pkg::RST_RATIO_D);
        gaps_on  = 1'b0;
        hold_req = hold_req + 1;
        repeat (40)
            send_event(rand_event());
        gaps_on = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        evt.valid    = 1'b0;
        evt.func     = rfs_pkg::FUNC_COLLISION;
        evt.imminent = 1'b0;
        evt.pos_x    = '0;
        evt.pos_y    = '0;
        evt.pos_z    = '0;
        evt.target_x = '0;
        evt.target_y = '0;
        evt.target_z = '0;
        cfg.valid    = 1'b0;
        cfg.index    = rfs_pkg::CFG_MAX_RETRIES;
        cfg.data     = '0;
        cfg_retries  = rfs_pkg::RST_MAX_RETRIES;
        cfg_step     = rfs_pkg::RST_WEIGHT_STEP;
        cfg_count    = rfs_pkg::RST_RATIO_COUNT;
        cfg_ratio[0] = rfs_pkg::RST_RATIO_A;
        cfg_ratio[1] = rfs_pkg::RST_RATIO_B;
        cfg_ratio[2] = rfs_pkg::RST_RATIO_C;
        cfg_ratio[3] = rfs_pkg::RST_RATIO_D;
        clear_sequencer();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_config_corners();
        test_random();
        test_backpressure();

        drain();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (pending_decisions.size() != 0)
            $display("%0d decisions still outstanding at end of run",
                     pending_decisions.size());

        $display("Covered %0d events, %0d decisions: %0d stops, %0d retries, %0d goals, %0d waits",
                 events_sent, results_seen, action_seen[rfs_pkg::ACT_ESTOP],
                 action_seen[rfs_pkg::ACT_RETRY], action_seen[rfs_pkg::ACT_SHORTEN],
                 action_seen[rfs_pkg::ACT_WAIT]);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 cfg_writes, settings_used, fault_count);
        if (fault_count == 0 && pending_decisions.size() == 0)
            $display("PASS replan_fallback_sequencer");
        else
            $display("FAIL replan_fallback_sequencer");
        $finish;
    end

endmodule
